@@ hdl/tbeds_pkg.sv @@
// package for the trackball edge debounce and scroll block
// holds item, result and state types, register indexes and reset values
// no dependencies
package tbeds_pkg;

  localparam int NumDirs = 4;
  localparam int TimeW = 32;
  localparam int CfgW = 16;
  localparam int CfgIdxW = 2;
  localparam int InDataW = 40;
  localparam int OutDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_TIME = 2'd0,
    REG_REPEAT_INTERVAL = 2'd1
  } cfg_reg_t;

  localparam logic [CfgW-1:0] DebounceReset = 16'd22;
  localparam logic [CfgW-1:0] RepeatReset = 16'd80;

  // direction order: up, down, left, right
  localparam int DirUp = 0;
  localparam int DirDown = 1;
  localparam int DirLeft = 2;
  localparam int DirRight = 3;

  localparam logic [1:0] StepNone = 2'b00;
  localparam logic [1:0] StepDown = 2'b01;
  localparam logic [1:0] StepUp = 2'b11;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [NumDirs-1:0] dir_pressed;
    logic click_pressed;
  } item_t;

  typedef struct packed {
    logic signed [1:0] scroll_step;
    logic click_event;
  } result_t;

  typedef struct packed {
    logic [NumDirs-1:0] dir_level;
    logic [NumDirs-1:0][TimeW-1:0] dir_change_time;
    logic click_level;
    logic click_consumed;
    logic [TimeW-1:0] click_change_time;
    logic [TimeW-1:0] last_step_time;
  } state_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] repeat_interval;
  } cfg_t;

endpackage

@@ hdl/trackball_edge_debounce_scroll_top.sv @@
// top level of the trackball edge debounce and scroll block
// input and output registers around tbeds_eval; uses tbeds_pkg
//
// usage:
//   s_* carries polls: s_tdata[31:0] now_ms, [32] up, [33] down, [34] left,
//   [35] right, [36] click, upper bits zero.
//   m_* carries one result per poll: m_tdata[1:0] scroll_step (signed),
//   [2] click_event, upper bits zero.
//   cfg_we/cfg_index/cfg_data write debounce_time (0) and repeat_interval (1);
//   other indexes are ignored; write only while the block is idle.
// timing:
//   a poll transferred into the input register is evaluated combinationally
//   and written to the output register when the output can advance; one poll
//   per cycle sustained while m_tready stays high, with the single evaluation
//   pass between the two registers.
// reset (rst, synchronous): all line levels released, all timers zero,
//   registers back to 22 and 80 ms, both stages empty.
// stall: while m_tready is low the result holds; the input register keeps
//   one more poll, then s_tready drops until the output moves.
module trackball_edge_debounce_scroll_top import tbeds_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // now_ms, up, down, left, right, click
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // scroll_step, click_event
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   in_reg;
  logic    in_valid;
  result_t res;
  result_t out_reg;
  logic    out_valid;
  logic    advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= DebounceReset;
      cfg.repeat_interval <= RepeatReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TIME:   cfg.debounce_time <= cfg_data;
        REG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg.now_ms <= s_tdata[31:0];
      in_reg.dir_pressed <= s_tdata[35:32];
      in_reg.click_pressed <= s_tdata[36];
    end
  end

  tbeds_eval u_eval (
    .item       (in_reg),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (res)
  );

  // line state, updated when a poll moves into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance && in_valid) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_reg <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {{(OutDataW-3){1'b0}}, out_reg.click_event, out_reg.scroll_step};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("stages not empty after reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid) |=> m_tvalid)
    else $error("evaluated poll lost");

  a_click_consumed: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && res.click_event) |=> state.click_consumed && state.click_level)
    else $error("click fired without arming consumed flag");

  a_step_time: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && (res.scroll_step != StepNone))
      |=> state.last_step_time == $past(in_reg.now_ms))
    else $error("step emitted without updating step time");

endmodule

@@ hdl/tbeds_eval.sv @@
// one-poll evaluation: debounced edges, scroll step and click event
// purely combinational; uses tbeds_pkg
module tbeds_eval import tbeds_pkg::*; (
  input  item_t   item,
  input  state_t  state,
  input  cfg_t    cfg,
  output state_t  state_next,
  output result_t result
);

  logic [TimeW-1:0] dir_diff [NumDirs];
  logic [NumDirs-1:0] dir_changed;
  logic [NumDirs-1:0] dir_hit;
  logic [1:0] neg_score;
  logic [1:0] pos_score;
  logic [TimeW-1:0] step_diff;
  logic step_open;
  logic [TimeW-1:0] debounce_ext;
  logic click_changed;
  logic [TimeW-1:0] click_time;
  logic click_ok;
  logic consumed_mid;
  logic fire;

  assign debounce_ext = {{(TimeW-CfgW){1'b0}}, cfg.debounce_time};

  always_comb begin
    state_next = state;
    for (int i = 0; i < NumDirs; i++) begin
      dir_changed[i] = item.dir_pressed[i] != state.dir_level[i];
      dir_diff[i] = item.now_ms - state.dir_change_time[i];
      dir_hit[i] = dir_changed[i] && item.dir_pressed[i] && (dir_diff[i] >= debounce_ext);
      if (dir_changed[i]) begin
        state_next.dir_change_time[i] = item.now_ms;
      end
    end
    state_next.dir_level = item.dir_pressed;

    neg_score = {1'b0, dir_hit[DirUp]} + {1'b0, dir_hit[DirLeft]};
    pos_score = {1'b0, dir_hit[DirDown]} + {1'b0, dir_hit[DirRight]};
    step_diff = item.now_ms - state.last_step_time;
    step_open = (|dir_hit) && (step_diff >= {{(TimeW-CfgW){1'b0}}, cfg.repeat_interval});
    result.scroll_step = StepNone;
    if (step_open && (neg_score > pos_score)) begin
      result.scroll_step = StepUp;
      state_next.last_step_time = item.now_ms;
    end else if (step_open && (pos_score > neg_score)) begin
      result.scroll_step = StepDown;
      state_next.last_step_time = item.now_ms;
    end

    // click: a change restarts the hold timer
    click_changed = item.click_pressed != state.click_level;
    click_time = click_changed ? item.now_ms : state.click_change_time;
    click_ok = (item.now_ms - click_time) >= debounce_ext;
    consumed_mid = (!item.click_pressed && click_ok) ? 1'b0 : state.click_consumed;
    fire = item.click_pressed && !consumed_mid && click_ok;
    state_next.click_level = item.click_pressed;
    state_next.click_change_time = click_time;
    state_next.click_consumed = consumed_mid | fire;
    result.click_event = fire;
  end

endmodule

@@ sim/tb_trackball_edge_debounce_scroll_top.sv @@
// testbench for trackball_edge_debounce_scroll_top: directed and random polls,
// with a scoreboard that predicts the scroll step and the click event of each poll
// depends on tbeds_pkg and the top level RTL only
`timescale 1ns / 1ps

module tb_trackball_edge_debounce_scroll_top;
  import tbeds_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam logic [NumDirs-1:0] UpLine = 4'b0001 << DirUp;
  localparam logic [NumDirs-1:0] DownLine = 4'b0001 << DirDown;
  localparam logic [NumDirs-1:0] LeftLine = 4'b0001 << DirLeft;
  localparam logic [NumDirs-1:0] RightLine = 4'b0001 << DirRight;
  localparam logic [NumDirs-1:0] NoLine = '0;
  localparam logic [NumDirs-1:0] AllLines = '1;

  class scroll_scoreboard;
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] step_gap_ms;
    logic [NumDirs-1:0] line_level;
    logic [TimeW-1:0] line_stamp [NumDirs];
    logic click_level;
    logic click_spent;
    logic [TimeW-1:0] click_stamp;
    logic [TimeW-1:0] step_stamp;
    result_t expected_q [$];
    int errors;

    function new();
      errors = 0;
      debounce_ms = DebounceReset;
      step_gap_ms = RepeatReset;
      line_level = '0;
      foreach (line_stamp[d]) line_stamp[d] = '0;
      click_level = 1'b0;
      click_spent = 1'b0;
      click_stamp = '0;
      step_stamp = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        REG_DEBOUNCE_TIME: debounce_ms = val;
        REG_REPEAT_INTERVAL: step_gap_ms = val;
        default: ;
      endcase
    endfunction

    function logic [TimeW-1:0] since(logic [TimeW-1:0] t, logic [TimeW-1:0] stamp);
      return t - stamp;
    endfunction

    function void note_poll(item_t poll);
      int minus_score;
      int down_score;
      result_t res;
      logic [TimeW-1:0] t;
      minus_score = 0;
      down_score = 0;
      t = poll.now_ms;
      res.scroll_step = StepNone;
      res.click_event = 1'b0;
      for (int d = 0; d < NumDirs; d++) begin
        if (poll.dir_pressed[d] != line_level[d]) begin
          line_level[d] = poll.dir_pressed[d];
          if (poll.dir_pressed[d] && since(t, line_stamp[d]) >= TimeW'(debounce_ms)) begin
            if (d == DirUp || d == DirLeft) minus_score++;
            else down_score++;
          end
          line_stamp[d] = t;
        end
      end
      if ((minus_score > 0 || down_score > 0) &&
          since(t, step_stamp) >= TimeW'(step_gap_ms)) begin
        if (minus_score > down_score) begin
          res.scroll_step = StepUp;
          step_stamp = t;
        end else if (down_score > minus_score) begin
          res.scroll_step = StepDown;
          step_stamp = t;
        end
      end
      if (poll.click_pressed != click_level) begin
        click_level = poll.click_pressed;
        click_stamp = t;
      end
      if (!click_level && since(t, click_stamp) >= TimeW'(debounce_ms)) click_spent = 1'b0;
      if (click_level && !click_spent && since(t, click_stamp) >= TimeW'(debounce_ms)) begin
        res.click_event = 1'b1;
        click_spent = 1'b1;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: scroll_step %0d click_event %0b",
               got.scroll_step, got.click_event);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.scroll_step !== want.scroll_step) begin
        $error("scroll_step: expected %0d, actual %0d", want.scroll_step, got.scroll_step);
        errors++;
      end
      if (got.click_event !== want.click_event) begin
        $error("click_event: expected %0b, actual %0b", want.click_event, got.click_event);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;   // now_ms, up, down, left, right, click
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;       // scroll_step, click_event
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  scroll_scoreboard sb = new();
  int send_odds = 4;
  int stall_odds = 4;
  int stall_left = 0;
  logic [TimeW-1:0] clock_ms = '0;
  logic [NumDirs-1:0] held_lines = '0;
  logic held_click = 1'b0;

  trackball_edge_debounce_scroll_top DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[trackball_edge_debounce_scroll_top] ERROR");
    $finish;
  end

  // output side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(12, 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_poll(item_t'{now_ms: s_tdata[TimeW-1:0],
                             dir_pressed: s_tdata[TimeW +: NumDirs],
                             click_pressed: s_tdata[TimeW+NumDirs]});
      if (m_tvalid && m_tready)
        sb.check_result(result_t'{scroll_step: m_tdata[1:0], click_event: m_tdata[2]});
    end
  end

  task automatic send_poll(item_t poll);
    int gap;
    gap = (send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) ?
          $urandom_range(13, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(InDataW-TimeW-NumDirs-1){1'b0}}, poll.click_pressed,
                poll.dir_pressed, poll.now_ms};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly press and release sequences on a running clock, some raw noise
  function automatic item_t next_poll();
    item_t p;
    if ($urandom_range(9, 0) == 0) begin
      p.now_ms = $urandom;
      p.dir_pressed = NumDirs'($urandom);
      p.click_pressed = 1'($urandom);
    end else begin
      case ($urandom_range(15, 0))
        0: clock_ms = $urandom;
        1: clock_ms = clock_ms + $urandom_range(131071, 0);
        default: clock_ms = clock_ms + $urandom_range(40, 0);
      endcase
      for (int d = 0; d < NumDirs; d++)
        if ($urandom_range(3, 0) == 0) held_lines[d] = ~held_lines[d];
      if ($urandom_range(3, 0) == 0) held_click = ~held_click;
      p.now_ms = clock_ms;
      p.dir_pressed = held_lines;
      p.click_pressed = held_click;
    end
    return p;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // edge judged against zero timers, release, repeat window, tie, wrap
    send_poll(item_t'{32'd0, NoLine, 1'b0});
    send_poll(item_t'{32'd0, UpLine, 1'b0});
    send_poll(item_t'{32'd5, NoLine, 1'b0});
    send_poll(item_t'{32'd100, DownLine, 1'b0});
    send_poll(item_t'{32'd120, NoLine, 1'b0});
    send_poll(item_t'{32'd150, UpLine, 1'b0});
    send_poll(item_t'{32'd170, NoLine, 1'b0});
    send_poll(item_t'{32'd300, UpLine | DownLine, 1'b0});
    send_poll(item_t'{32'd400, NoLine, 1'b0});
    send_poll(item_t'{32'd500, LeftLine, 1'b1});
    send_poll(item_t'{32'd530, LeftLine, 1'b1});
    send_poll(item_t'{32'd560, NoLine, 1'b1});
    send_poll(item_t'{32'd600, RightLine, 1'b0});
    send_poll(item_t'{32'd700, NoLine, 1'b0});
    send_poll(item_t'{32'd710, NoLine, 1'b1});
    send_poll(item_t'{32'd740, NoLine, 1'b1});
    send_poll(item_t'{32'hFFFF_FFF0, UpLine | LeftLine, 1'b0});
    send_poll(item_t'{32'hFFFF_FFFF, NoLine, 1'b0});
    send_poll(item_t'{32'h0000_0040, DownLine | RightLine, 1'b0});
    send_poll(item_t'{32'h0000_0041, AllLines, 1'b1});
    send_poll(item_t'{32'hFFFF_FFFF, AllLines, 1'b1});
    send_poll(item_t'{32'h0000_1000, NoLine, 1'b0});

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_DEBOUNCE_TIME, 16'h0000);
          write_reg(REG_REPEAT_INTERVAL, 16'h0000);
        end
        1: begin
          write_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
          write_reg(REG_REPEAT_INTERVAL, 16'hFFFF);
          write_reg(RegSpare2, 16'h0000);
          write_reg(RegSpare3, 16'h0001);
        end
        3: begin
          write_reg(REG_DEBOUNCE_TIME, 16'($urandom));
          write_reg(REG_REPEAT_INTERVAL, 16'($urandom));
        end
        4: begin
          write_reg(REG_DEBOUNCE_TIME, DebounceReset);
          write_reg(REG_REPEAT_INTERVAL, RepeatReset);
        end
        default: begin
          write_reg(REG_DEBOUNCE_TIME, 16'($urandom_range(40, 0)));
          write_reg(REG_REPEAT_INTERVAL, 16'($urandom_range(120, 0)));
        end
      endcase
      send_odds = (ph == 2 || ph == 5) ? 0 : 3 + ph;
      stall_odds = (ph == 2 || ph == 5) ? 0 : 6 - ph;
      repeat (85) send_poll(next_poll());
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[trackball_edge_debounce_scroll_top] OK");
    else
      $display("[trackball_edge_debounce_scroll_top] ERROR");
    $finish;
  end

endmodule
